### rtl/core/cbr_pkg.sv
package cbr_pkg;

  // default geometry handed to the top level parameters
  localparam int DEF_MAX_COLS     = 256;
  localparam int DEF_MAX_ROWS     = 256;
  localparam int DEF_CLEAR_RADIUS = 3;

  // item commands
  localparam logic [1:0] CMD_FRAME = 2'd0;
  localparam logic [1:0] CMD_BOX   = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INFLATION     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN_COST  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FREE_COST     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OBSTACLE_COST = 3'd6;

  // register reset values
  localparam logic [15:0] RST_CELL_SIZE     = 16'd26;
  localparam logic [8:0]  RST_GRID_WIDTH    = 9'd200;
  localparam logic [8:0]  RST_GRID_HEIGHT   = 9'd200;
  localparam logic [15:0] RST_INFLATION     = 16'd0;
  localparam logic [7:0]  RST_UNKNOWN_COST  = 8'hFF;
  localparam logic [7:0]  RST_FREE_COST     = 8'h00;
  localparam logic [7:0]  RST_OBSTACLE_COST = 8'd100;

  // value the grid holds after reset
  localparam logic [7:0] CLEAR_COST = 8'hFF;

  // payload widths
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 8;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_FILL,
    ST_SQUARE,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_RECT_INIT,
    ST_RECT_RD,
    ST_RECT_WR,
    ST_READ,
    ST_DONE
  } cbr_state_t;

  typedef struct packed {
    logic load;
    logic fill_we;
    logic fill_clear;
    logic sq_step;
    logic prep;
    logic mul;
    logic div_step;
    logic rect_init;
    logic rect_rd;
    logic rect_wr;
    logic rd_issue;
    logic res_load;
  } cbr_ctl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       fill_last;
    logic       sq_last;
    logic       div_all;
    logic       rect_last;
    logic       out_free;
  } cbr_sts_t;

endpackage

### rtl/core/costmap_box_rasterizer_top.sv
// Read item: the cell is read from the grid RAM into the result register; an unused
// command goes straight to a zero result. Mark box: corners ordered, inflated and scaled,
// divided in turn (divider width clog2 of size + 18), then each cell read and written.
// Begin frame: whole store, then (2*CLEAR_RADIUS+1)^2 square, on the single RAM port.
// One item in flight. Reset: synchronous, active low; a clearing pass over the store
// sets every cell to -1 before the first item is taken.
module costmap_box_rasterizer_top #(
  parameter int MAX_COLS     = cbr_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS     = cbr_pkg::DEF_MAX_ROWS,
  parameter int CLEAR_RADIUS = cbr_pkg::DEF_CLEAR_RADIUS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // tdata: box_min_x, box_min_y, box_max_x, box_max_y, read_col, read_row
  input  logic [cbr_pkg::IN_DATA_W-1:0]  in_tdata,
  // tuser: cmd
  input  logic [1:0]                     in_tuser,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // tdata: cell_cost
  output logic [cbr_pkg::OUT_DATA_W-1:0] out_tdata,
  // tuser: cell_valid
  output logic                           out_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cbr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cbr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cbr_pkg::*;

  cbr_ctl_t ctl;
  cbr_sts_t sts;

  // registers always take writes
  assign cfg_ready = 1'b1;

  cbr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  cbr_datapath #(
    .MAX_COLS     (MAX_COLS),
    .MAX_ROWS     (MAX_ROWS),
    .CLEAR_RADIUS (CLEAR_RADIUS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .sts        (sts),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_cmd   (in_tuser),
    .item_data  (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

### rtl/core/cbr_ram.sv
module cbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read that holds until the next read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

### rtl/core/cbr_ctrl.sv
module cbr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  cbr_pkg::cbr_sts_t sts,
  output cbr_pkg::cbr_ctl_t ctl
);
  import cbr_pkg::*;

  cbr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:     if (sts.fill_last) state_nxt = ST_IDLE;
      ST_IDLE:      if (in_tvalid) state_nxt = ST_DISPATCH;
      ST_DISPATCH: begin
        unique case (sts.cmd)
          CMD_FRAME: state_nxt = ST_FILL;
          CMD_BOX:   state_nxt = ST_PREP;
          CMD_READ:  state_nxt = ST_READ;
          default:   state_nxt = ST_DONE;
        endcase
      end
      ST_FILL:      if (sts.fill_last) state_nxt = ST_SQUARE;
      ST_SQUARE:    if (sts.sq_last) state_nxt = ST_DONE;
      ST_PREP:      state_nxt = ST_MUL;
      ST_MUL:       state_nxt = ST_DIV;
      ST_DIV:       if (sts.div_all) state_nxt = ST_RECT_INIT;
      ST_RECT_INIT: state_nxt = ST_RECT_RD;
      ST_RECT_RD:   state_nxt = ST_RECT_WR;
      ST_RECT_WR:   state_nxt = sts.rect_last ? ST_DONE : ST_RECT_RD;
      ST_READ:      state_nxt = ST_DONE;
      ST_DONE:      if (sts.out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    ctl       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        ctl.fill_we    = 1'b1;
        ctl.fill_clear = 1'b1;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        ctl.load  = in_tvalid;
      end
      ST_FILL:      ctl.fill_we   = 1'b1;
      ST_SQUARE:    ctl.sq_step   = 1'b1;
      ST_PREP:      ctl.prep      = 1'b1;
      ST_MUL:       ctl.mul       = 1'b1;
      ST_DIV:       ctl.div_step  = 1'b1;
      ST_RECT_INIT: ctl.rect_init = 1'b1;
      ST_RECT_RD:   ctl.rect_rd   = 1'b1;
      ST_RECT_WR:   ctl.rect_wr   = 1'b1;
      ST_READ:      ctl.rd_issue  = 1'b1;
      ST_DONE:      ctl.res_load  = sts.out_free;
      default:      ctl = '0;
    endcase
  end

endmodule

### rtl/core/cbr_datapath.sv
module cbr_datapath #(
  parameter int MAX_COLS     = cbr_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS     = cbr_pkg::DEF_MAX_ROWS,
  parameter int CLEAR_RADIUS = cbr_pkg::DEF_CLEAR_RADIUS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  cbr_pkg::cbr_ctl_t                  ctl,
  output cbr_pkg::cbr_sts_t                  sts,
  input  logic                               cfg_we,
  input  logic [cbr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cbr_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [1:0]                         item_cmd,
  input  logic [cbr_pkg::IN_DATA_W-1:0]      item_data,
  input  logic                               out_tready,
  output logic                               out_tvalid,
  output logic [cbr_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                               out_tuser
);
  import cbr_pkg::*;

  localparam int CA   = $clog2(MAX_COLS);
  localparam int RA   = $clog2(MAX_ROWS);
  localparam int AW   = CA + RA;
  localparam int NCW  = $clog2(MAX_COLS + 1);
  localparam int NRW  = $clog2(MAX_ROWS + 1);
  localparam int NW   = (NCW > NRW) ? NCW : NRW;
  localparam int GW   = (NW > 9) ? NW : 9;
  localparam int PW   = NW + 16;
  localparam int NUMW = NW + 18;
  localparam int BCW  = $clog2(NUMW + 1);
  localparam int SW   = NW + 6;
  localparam int RCW  = $clog2(2 * CLEAR_RADIUS + 2);
  localparam logic [RCW-1:0] SPAN = RCW'(2 * CLEAR_RADIUS);
  localparam logic [BCW-1:0] BC_LAST = BCW'(NUMW - 1);

  // configuration registers
  logic        [15:0] cell_size_r, inflation_r;
  logic        [8:0]  grid_width_r, grid_height_r;
  logic        [7:0]  unknown_r, free_r, obstacle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_size_r   <= RST_CELL_SIZE;
      grid_width_r  <= RST_GRID_WIDTH;
      grid_height_r <= RST_GRID_HEIGHT;
      inflation_r   <= RST_INFLATION;
      unknown_r     <= RST_UNKNOWN_COST;
      free_r        <= RST_FREE_COST;
      obstacle_r    <= RST_OBSTACLE_COST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CELL_SIZE:     cell_size_r   <= cfg_data;
        REG_GRID_WIDTH:    grid_width_r  <= cfg_data[8:0];
        REG_GRID_HEIGHT:   grid_height_r <= cfg_data[8:0];
        REG_INFLATION:     inflation_r   <= cfg_data;
        REG_UNKNOWN_COST:  unknown_r     <= cfg_data[7:0];
        REG_FREE_COST:     free_r        <= cfg_data[7:0];
        REG_OBSTACLE_COST: obstacle_r    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // effective grid size and cell size
  logic [GW-1:0] gw_ext, gh_ext, gw_sat, gh_sat;
  logic [NW-1:0] eff_w, eff_h;
  logic [15:0]   cs_eff;

  always_comb begin
    gw_ext = GW'(grid_width_r);
    gh_ext = GW'(grid_height_r);
    priority if (gw_ext == '0)               gw_sat = GW'(1);
    else if (gw_ext > GW'(MAX_COLS))         gw_sat = GW'(MAX_COLS);
    else                                     gw_sat = gw_ext;
    priority if (gh_ext == '0)               gh_sat = GW'(1);
    else if (gh_ext > GW'(MAX_ROWS))         gh_sat = GW'(MAX_ROWS);
    else                                     gh_sat = gh_ext;
    eff_w  = NW'(gw_sat);
    eff_h  = NW'(gh_sat);
    cs_eff = (cell_size_r == '0) ? 16'd1 : cell_size_r;
  end

  // item registers
  logic        [1:0]  cmd_r;
  logic signed [15:0] ax_r, ay_r, bx_r, by_r;
  logic        [7:0]  col_r, row_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= item_cmd;
      ax_r  <= item_data[15:0];
      ay_r  <= item_data[31:16];
      bx_r  <= item_data[47:32];
      by_r  <= item_data[63:48];
      col_r <= item_data[71:64];
      row_r <= item_data[79:72];
    end
  end

  // whole-store sweep address
  logic [AW-1:0] sweep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
    end else if (ctl.fill_we) begin
      sweep_r <= sweep_r + AW'(1);
    end
  end

  // free square around the origin cell
  logic [RCW-1:0]       dx_r, dy_r;
  logic signed [SW-1:0] sq_x, sq_y;
  logic                 sq_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dx_r <= '0;
      dy_r <= '0;
    end else if (ctl.sq_step) begin
      if (dx_r == SPAN) begin
        dx_r <= '0;
        dy_r <= (dy_r == SPAN) ? '0 : dy_r + RCW'(1);
      end else begin
        dx_r <= dx_r + RCW'(1);
      end
    end
  end

  always_comb begin
    sq_x  = $signed(SW'(eff_w >> 1)) - $signed(SW'(CLEAR_RADIUS)) + $signed(SW'(dx_r));
    sq_y  = $signed(SW'(eff_h >> 1)) - $signed(SW'(CLEAR_RADIUS)) + $signed(SW'(dy_r));
    sq_in = (sq_x >= 0) && (sq_x < $signed(SW'(eff_w))) &&
            (sq_y >= 0) && (sq_y < $signed(SW'(eff_h)));
  end

  // ordered and inflated corners: x0, y0, x1, y1
  logic signed [17:0] crd_r [4];
  logic signed [17:0] infl_s;

  assign infl_s = $signed({2'b00, inflation_r});

  always_ff @(posedge clk) begin
    if (ctl.prep) begin
      crd_r[0] <= ((ax_r < bx_r) ? 18'(ax_r) : 18'(bx_r)) - infl_s;
      crd_r[1] <= ((ay_r < by_r) ? 18'(ay_r) : 18'(by_r)) - infl_s;
      crd_r[2] <= ((ax_r < bx_r) ? 18'(bx_r) : 18'(ax_r)) + infl_s;
      crd_r[3] <= ((ay_r < by_r) ? 18'(by_r) : 18'(ay_r)) + infl_s;
    end
  end

  // full extents n * cell_size
  logic [PW-1:0] prod_w_r, prod_h_r;

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod_w_r <= PW'(eff_w) * PW'(cs_eff);
      prod_h_r <= PW'(eff_h) * PW'(cs_eff);
    end
  end

  // shared restoring divider, one quotient bit a cycle, four corners in turn
  logic [1:0]             k_r;
  logic                   dv_load_r;
  logic [BCW-1:0]         bc_r;
  logic [NUMW-1:0]        mag_r;
  logic [17:0]            rem_r;
  logic                   neg_r;
  logic signed [NUMW:0]   cell_r [4];
  logic signed [NUMW-1:0] num;
  logic [NUMW-1:0]        num_mag, q_fin;
  logic [17:0]            den, rem_sh, rem_fin;
  logic                   ge;
  logic signed [NUMW:0]   q_s, cell_fin;

  always_comb begin
    num     = (NUMW'(crd_r[k_r]) <<< 1) +
              $signed(NUMW'(k_r[0] ? prod_h_r : prod_w_r));
    num_mag = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
    den     = {1'b0, cs_eff, 1'b0};
    rem_sh  = {rem_r[16:0], mag_r[NUMW-1]};
    ge      = rem_sh >= den;
    rem_fin = ge ? rem_sh - den : rem_sh;
    q_fin   = {mag_r[NUMW-2:0], ge};
    q_s     = $signed({1'b0, q_fin});
    cell_fin = neg_r ? -(q_s + $signed((NUMW+1)'(rem_fin != '0))) : q_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r       <= '0;
      dv_load_r <= 1'b1;
      bc_r      <= '0;
    end else if (ctl.div_step) begin
      if (dv_load_r) begin
        dv_load_r <= 1'b0;
        bc_r      <= '0;
      end else if (bc_r == BC_LAST) begin
        dv_load_r <= 1'b1;
        bc_r      <= '0;
        k_r       <= k_r + 2'd1;
      end else begin
        bc_r <= bc_r + BCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.div_step) begin
      if (dv_load_r) begin
        mag_r <= num_mag;
        neg_r <= num[NUMW-1];
        rem_r <= '0;
      end else begin
        mag_r <= q_fin;
        rem_r <= rem_fin;
        if (bc_r == BC_LAST) begin
          cell_r[k_r] <= cell_fin;
        end
      end
    end
  end

  // order cells, clamp to the grid, walk the rectangle
  function automatic logic [NW-1:0] clamp_cell(input logic signed [NUMW:0] v,
                                               input logic [NW-1:0] n);
    logic signed [NUMW:0] top;
    top = $signed((NUMW+1)'(n - NW'(1)));
    if (v < 0) begin
      return '0;
    end else if (v > top) begin
      return n - NW'(1);
    end else begin
      return NW'(v);
    end
  endfunction

  logic [CA-1:0] rx_r, x0_r, x1_r;
  logic [RA-1:0] ry_r, y1_r;
  logic [7:0]    rdata, raised;

  always_ff @(posedge clk) begin
    if (ctl.rect_init) begin
      x0_r <= CA'(clamp_cell((cell_r[0] < cell_r[2]) ? cell_r[0] : cell_r[2], eff_w));
      x1_r <= CA'(clamp_cell((cell_r[0] < cell_r[2]) ? cell_r[2] : cell_r[0], eff_w));
      rx_r <= CA'(clamp_cell((cell_r[0] < cell_r[2]) ? cell_r[0] : cell_r[2], eff_w));
      ry_r <= RA'(clamp_cell((cell_r[1] < cell_r[3]) ? cell_r[1] : cell_r[3], eff_h));
      y1_r <= RA'(clamp_cell((cell_r[1] < cell_r[3]) ? cell_r[3] : cell_r[1], eff_h));
    end else if (ctl.rect_wr) begin
      if (rx_r == x1_r) begin
        rx_r <= x0_r;
        ry_r <= ry_r + RA'(1);
      end else begin
        rx_r <= rx_r + CA'(1);
      end
    end
  end

  assign raised = ($signed(rdata) < $signed(obstacle_r)) ? obstacle_r : rdata;

  // read range check
  logic read_in;
  assign read_in = (GW'(col_r) < GW'(eff_w)) && (GW'(row_r) < GW'(eff_h));

  // grid memory port selection
  logic [AW-1:0] mem_addr;
  logic          mem_we, mem_re;
  logic [7:0]    mem_wdata;

  always_comb begin
    mem_addr  = '0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wdata = '0;
    priority if (ctl.fill_we) begin
      mem_addr  = sweep_r;
      mem_we    = 1'b1;
      mem_wdata = ctl.fill_clear ? CLEAR_COST : unknown_r;
    end else if (ctl.sq_step) begin
      mem_addr  = {RA'(sq_y), CA'(sq_x)};
      mem_we    = sq_in;
      mem_wdata = free_r;
    end else if (ctl.rect_rd) begin
      mem_addr = {ry_r, rx_r};
      mem_re   = 1'b1;
    end else if (ctl.rect_wr) begin
      mem_addr  = {ry_r, rx_r};
      mem_we    = 1'b1;
      mem_wdata = raised;
    end else if (ctl.rd_issue) begin
      mem_addr = {RA'(row_r), CA'(col_r)};
      mem_re   = 1'b1;
    end
  end

  cbr_ram #(
    .WIDTH (8),
    .DEPTH (1 << AW)
  ) u_grid (
    .clk   (clk),
    .addr  (mem_addr),
    .we    (mem_we),
    .wdata (mem_wdata),
    .re    (mem_re),
    .rdata (rdata)
  );

  // result register
  logic       out_valid_r;
  logic [7:0] out_cost_r;
  logic       out_in_r;
  logic       res_hit;

  assign res_hit = (cmd_r == CMD_READ) && read_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.res_load) begin
      out_cost_r <= res_hit ? rdata : 8'h00;
      out_in_r   <= res_hit;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_cost_r;
  assign out_tuser  = out_in_r;

  // status
  always_comb begin
    sts.cmd       = cmd_r;
    sts.fill_last = &sweep_r;
    sts.sq_last   = (dx_r == SPAN) && (dy_r == SPAN);
    sts.div_all   = (k_r == 2'd3) && !dv_load_r && (bc_r == BC_LAST);
    sts.rect_last = (rx_r == x1_r) && (ry_r == y1_r);
    sts.out_free  = !out_valid_r || out_tready;
  end

endmodule

### rtl/core/cbr_checker.sv
module cbr_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [cbr_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // one item at a time: intake closes right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while busy");

  // a cell outside the grid or a non-read item reports zero cost
  a_zero_cost: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("cost without a valid cell");

  // the clearing pass blocks input right after reset
  a_clear_pass: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input open during clearing pass");

endmodule

bind costmap_box_rasterizer_top cbr_checker u_cbr_checker (.*);
